// File: rtl/core/hmpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Max-heap priority queue package
// Sizes, storage types, operation and status codes shared by the queue RTL.
// ----------------------------------------------------------------------------
package hmpq_pkg;

    localparam int HEAP_CAPACITY = 64;
    localparam int VALUE_WIDTH   = 32;

    // Fixed port widths
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 7;

    // Count and heap position (1-based) need to hold the capacity itself
    localparam int CNT_W  = $clog2(HEAP_CAPACITY + 1);
    localparam int ADDR_W = $clog2(HEAP_CAPACITY);

    typedef logic signed [VALUE_WIDTH-1:0] t_val;
    typedef logic [CNT_W-1:0]              t_pos;
    typedef logic [CNT_W:0]                t_child;
    typedef logic [ADDR_W-1:0]             t_addr;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    localparam t_pos POS_ROOT = t_pos'(1);
    localparam t_pos POS_CAP  = t_pos'(HEAP_CAPACITY);

    // Heap position 1..CAPACITY lives at store address 0..CAPACITY-1
    function automatic t_addr pos_to_addr(input t_pos p);
        t_pos d;
        d = p - POS_ROOT;
        return d[ADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/binary_max_heap_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary max-heap priority queue
// Inserts signed values or removes the maximum, one result beat per item.
// ----------------------------------------------------------------------------
// The queue works on one item at a time and stalls its input while busy. An
// insert walks up the heap level by level (read the parent, then compare and
// write), a removal walks down level by level (read left child, read right
// child if it exists, compare and write); both are set by the single
// registered read port of the heap store. The root is kept in a register, so
// the removed value and the new top need no extra read. The result sits in an
// output register, so a new item may be taken while the previous result still
// waits to be collected.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic                                 i_mode,
    input  wire logic signed [hmpq_pkg::KEY_W-1:0]    i_key_value,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic        [hmpq_pkg::STATUS_W-1:0]      o_status,
    output logic signed [hmpq_pkg::KEY_W-1:0]         o_removed_value,
    output logic signed [hmpq_pkg::KEY_W-1:0]         o_top_value,
    output logic        [hmpq_pkg::TOTAL_W-1:0]       o_entry_total
);
    import hmpq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_UP_RD   = 8'b0000_0010,
        S_UP_CMP  = 8'b0000_0100,
        S_DN_LAST = 8'b0000_1000,
        S_DN_RD   = 8'b0001_0000,
        S_DN_LC   = 8'b0010_0000,
        S_DN_RC   = 8'b0100_0000,
        S_FIN     = 8'b1000_0000
    } t_state;

    t_val r_mem [HEAP_CAPACITY];
    t_val r_rd_data;

    t_state               r_state,   n_state;
    t_pos                 r_count,   n_count;
    t_pos                 r_pos,     n_pos;
    t_val                 r_val,     n_val;
    t_val                 r_bestval, n_bestval;
    logic                 r_best_l,  n_best_l;
    t_val                 r_top;
    logic [STATUS_W-1:0]  r_status,  n_status;
    t_val                 r_removed, n_removed;

    logic  rd_en;
    t_addr rd_addr;
    logic  wr_en;
    t_pos  wr_pos;
    t_val  wr_data;

    logic   in_accept;
    logic   out_free;
    t_child lc;
    t_child rc;
    t_child cnt_ext;
    logic   rc_live;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !o_out_valid || !i_out_stall;
    assign lc        = {r_pos, 1'b0};
    assign rc        = {r_pos, 1'b1};
    assign cnt_ext   = {1'b0, r_count};
    assign rc_live   = (rc <= cnt_ext);

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_val     = r_val;
        n_bestval = r_bestval;
        n_best_l  = r_best_l;
        n_status  = r_status;
        n_removed = r_removed;
        rd_en     = 1'b0;
        rd_addr   = pos_to_addr(r_count);
        wr_en     = 1'b0;
        wr_pos    = r_pos;
        wr_data   = r_val;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_removed = '0;
                    n_status  = STATUS_OK;
                    if (i_mode == MODE_INSERT) begin
                        if (r_count >= POS_CAP) begin
                            n_status = STATUS_FULL;
                            n_state  = S_FIN;
                        end else begin
                            n_count = r_count + POS_ROOT;
                            n_pos   = r_count + POS_ROOT;
                            n_val   = VALUE_WIDTH'(i_key_value);
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = STATUS_EMPTY;
                            n_state  = S_FIN;
                        end else begin
                            // root is held in r_top; fetch the last entry
                            n_removed = r_top;
                            rd_en     = 1'b1;
                            rd_addr   = pos_to_addr(r_count);
                            n_count   = r_count - POS_ROOT;
                            n_state   = S_DN_LAST;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == POS_ROOT) begin
                    wr_en   = 1'b1;
                    n_state = S_FIN;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = pos_to_addr(r_pos >> 1);
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                wr_en = 1'b1;
                if (r_val > r_rd_data) begin
                    // move the parent down into the hole and climb
                    wr_data = r_rd_data;
                    n_pos   = r_pos >> 1;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DN_LAST: begin
                n_val = r_rd_data;
                n_pos = POS_ROOT;
                if (r_count == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_DN_RD;
                end
            end
            S_DN_RD: begin
                if (lc > cnt_ext) begin
                    wr_en   = 1'b1;
                    n_state = S_FIN;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = pos_to_addr(lc[CNT_W-1:0]);
                    n_state = S_DN_LC;
                end
            end
            S_DN_LC: begin
                if (rc_live) begin
                    if (r_val < r_rd_data) begin
                        n_best_l  = 1'b1;
                        n_bestval = r_rd_data;
                    end else begin
                        n_best_l  = 1'b0;
                        n_bestval = r_val;
                    end
                    rd_en   = 1'b1;
                    rd_addr = pos_to_addr(rc[CNT_W-1:0]);
                    n_state = S_DN_RC;
                end else begin
                    wr_en = 1'b1;
                    if (r_val < r_rd_data) begin
                        wr_data = r_rd_data;
                        n_pos   = lc[CNT_W-1:0];
                        n_state = S_DN_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_DN_RC: begin
                wr_en = 1'b1;
                if (r_bestval < r_rd_data) begin
                    wr_data = r_rd_data;
                    n_pos   = rc[CNT_W-1:0];
                    n_state = S_DN_RD;
                end else if (r_best_l) begin
                    wr_data = r_bestval;
                    n_pos   = lc[CNT_W-1:0];
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Heap store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[pos_to_addr(wr_pos)] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_FIN && out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_val     <= n_val;
        r_bestval <= n_bestval;
        r_best_l  <= n_best_l;
        r_status  <= n_status;
        r_removed <= n_removed;
        // mirror every write to the root
        if (wr_en && wr_pos == POS_ROOT) begin
            r_top <= wr_data;
        end
        // load the result beat
        if (r_state == S_FIN && out_free) begin
            o_status        <= r_status;
            o_removed_value <= KEY_W'(r_removed);
            o_top_value     <= (r_count == '0) ? '0 : KEY_W'(r_top);
            o_entry_total   <= TOTAL_W'(r_count);
        end
    end

endmodule
`default_nettype wire
